// File: sv/gcp_pkg.sv
// Shared constants, types and structs of the genotype consensus phaser.
package gcp_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int AGR_W       = IDX_W + 2;
    localparam int CFG_W       = 11;

    localparam logic [1:0] GENO_HOM_REF = 2'd0;
    localparam logic [1:0] GENO_HET     = 2'd1;
    localparam logic [1:0] GENO_HOM_ALT = 2'd2;

    typedef struct packed {
        logic [1:0] prev;
        logic [1:0] cur;
    } word_t;

    typedef struct packed {
        logic       step;
        logic       final_sample;
        logic       hap_a;
        logic       hap_b;
        logic       compare;
        logic [1:0] prev;
        logic [1:0] ties;
    } tally_in_t;

    typedef struct packed {
        logic [1:0] geno;
        logic       trans;
    } tally_out_t;

    typedef enum logic [1:0] {
        ST_RUN   = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

endpackage

// File: sv/gcp_if.sv
// Channel interfaces for samples, results and the configuration write port.
interface gcp_sample_if;
    logic       valid;
    logic       ready;
    logic       first_hap_sample;
    logic       second_hap_sample;
    logic [1:0] tie_bits;
    logic       last_site;

    modport source (output valid, first_hap_sample, second_hap_sample, tie_bits, last_site,
                    input ready);
    modport sink (input valid, first_hap_sample, second_hap_sample, tie_bits, last_site,
                  output ready);
endinterface

interface gcp_result_if;
    logic       valid;
    logic       ready;
    logic       hap_first;
    logic       hap_second;
    logic [1:0] genotype;
    logic       is_het;
    logic       end_of_individual;

    modport source (output valid, hap_first, hap_second, genotype, is_het, end_of_individual,
                    input ready);
    modport sink (input valid, hap_first, hap_second, genotype, is_het, end_of_individual,
                  output ready);
endinterface

interface gcp_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] sample_count;

    modport source (output valid, sample_count, input ready);
    modport sink (input valid, sample_count, output ready);
endinterface

// File: sv/gcp_sample_ram.sv
// Sample store: one read port with registered data and one write port.
module gcp_sample_ram (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [gcp_pkg::IDX_W-1:0] rd_addr,
    output gcp_pkg::word_t           rd_data,
    input  logic                     wr_en,
    input  logic [gcp_pkg::IDX_W-1:0] wr_addr,
    input  gcp_pkg::word_t           wr_data
);
    import gcp_pkg::*;

    word_t mem [MAX_SAMPLES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: sv/gcp_tally.sv
// Per-site genotype counters, allele agreement counters and the consensus vote.
module gcp_tally (
    input  logic                clk,
    input  logic                rst_n,
    input  gcp_pkg::tally_in_t  tin,
    output gcp_pkg::tally_out_t tout
);
    import gcp_pkg::*;

    logic [CNT_W-1:0] cnt_reg [3];
    logic [CNT_W-1:0] cnt_next [3];
    logic [AGR_W-1:0] agree_reg;
    logic [AGR_W-1:0] agree_next;
    logic [AGR_W-1:0] disagree_reg;
    logic [AGR_W-1:0] disagree_next;
    logic [1:0]       sum;
    logic [1:0]       agree_inc;
    logic [1:0]       geno;
    logic [CNT_W-1:0] best;

    always_comb
    begin
        sum = {1'b0, tin.hap_a} + {1'b0, tin.hap_b};
        for (int g = 0; g < 3; g++)
        begin
            cnt_next[g] = cnt_reg[g] + CNT_W'(sum == 2'(g));
        end
        agree_inc = {1'b0, tin.hap_a == tin.prev[0]} + {1'b0, tin.hap_b == tin.prev[1]};
        agree_next = agree_reg;
        disagree_next = disagree_reg;
        if (tin.compare)
        begin
            agree_next = agree_reg + AGR_W'(agree_inc);
            disagree_next = disagree_reg + AGR_W'(2'd2 - agree_inc);
        end

        geno = GENO_HOM_REF;
        best = '0;
        if (cnt_next[0] != '0)
        begin
            best = cnt_next[0];
        end
        if (cnt_next[1] != '0 &&
            (cnt_next[1] > best || (cnt_next[1] == best && tin.ties[0])))
        begin
            geno = GENO_HET;
            best = cnt_next[1];
        end
        if (cnt_next[2] != '0 &&
            (cnt_next[2] > best || (cnt_next[2] == best && tin.ties[1])))
        begin
            geno = GENO_HOM_ALT;
        end

        tout.geno = geno;
        tout.trans = agree_next < disagree_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < 3; g++)
            begin
                cnt_reg[g] <= '0;
            end
            agree_reg <= '0;
            disagree_reg <= '0;
        end
        else if (tin.step)
        begin
            for (int g = 0; g < 3; g++)
            begin
                cnt_reg[g] <= tin.final_sample ? '0 : cnt_next[g];
            end
            agree_reg <= tin.final_sample ? '0 : agree_next;
            disagree_reg <= tin.final_sample ? '0 : disagree_next;
        end
    end

endmodule

// File: sv/genotype_consensus_phaser_core.sv
// Top level of the genotype consensus phaser: sample pipeline, phasing state and channels.
//
// The block takes one sample transaction per clock while it is not stalled and returns one
// result transaction per site from its output register, after the site's final sample has
// passed the stage-1 register. Each sample reads and rewrites one word of a 1024-entry sample
// memory with registered read data; the word holds the sample of the current site and that of
// the last heterozygous site, and the copy of a heterozygous site into the previous-site slot
// happens word by word as the next site passes the same entries. When a site ends shorter than
// the last heterozygous site still awaiting that copy, which only happens after sample_count is
// lowered, the block stops taking samples while it finishes the copy, reading and rewriting each
// remaining entry in turn. A result waiting on a stalled output does not stop samples that end
// no site.
module genotype_consensus_phaser_core (
    input  logic         clk,
    input  logic         rst_n,
    gcp_cfg_if.sink      cfg,
    gcp_sample_if.sink   samples,
    gcp_result_if.source results
);
    import gcp_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CFG_W-1:0] count_cfg_reg;
    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] index_reg;
    logic             final0;
    logic             accept;

    logic             s1_valid_reg;
    logic             s1_a_reg;
    logic             s1_b_reg;
    logic [1:0]       s1_ties_reg;
    logic             s1_last_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s1_final_reg;
    logic             s1_go;
    logic             s1_needs_sweep;
    logic [CNT_W-1:0] s1_len;

    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_addr_reg;
    word_t            fwd_word_reg;

    word_t            rd_data;
    word_t            s1_word;
    word_t            new_word;
    logic [1:0]       prev_eff;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    word_t            wr_data;

    logic [CNT_W-1:0] pend_reg;
    logic             have_prev_reg;
    logic             orient_reg;
    logic             orient_het;

    logic [CNT_W-1:0] sw_rd_reg;
    logic [CNT_W-1:0] sw_end_reg;
    logic             sw_wr_valid_reg;
    logic [IDX_W-1:0] sw_wr_addr_reg;
    logic             sw_read;

    logic             out_valid_reg;
    logic             out_h1_reg;
    logic             out_h2_reg;
    logic [1:0]       out_geno_reg;
    logic             out_het_reg;
    logic             out_last_reg;

    tally_in_t        tin;
    tally_out_t       tout;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_cfg_reg <= CFG_W'(1);
        end
        else if (cfg.valid)
        begin
            count_cfg_reg <= cfg.sample_count;
        end
    end

    always_comb
    begin
        if (count_cfg_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (count_cfg_reg > CFG_W'(MAX_SAMPLES))
        begin
            n_eff = CNT_W'(MAX_SAMPLES);
        end
        else
        begin
            n_eff = CNT_W'(count_cfg_reg);
        end
    end

    assign s1_len = {1'b0, s1_idx_reg} + CNT_W'(1);
    assign s1_needs_sweep = s1_final_reg && (s1_len < pend_reg);
    assign s1_go = s1_valid_reg && (!s1_final_reg || !out_valid_reg || results.ready);
    assign samples.ready = (state_reg == ST_RUN) &&
                           (!s1_valid_reg || (s1_go && !s1_needs_sweep));
    assign accept = samples.valid && samples.ready;
    assign final0 = ({1'b0, index_reg} + CNT_W'(1)) >= n_eff;

    assign sw_read = (state_reg == ST_SWEEP) && (sw_rd_reg < sw_end_reg);
    assign rd_en = accept || sw_read;
    assign rd_addr = sw_read ? sw_rd_reg[IDX_W-1:0] : index_reg;

    always_comb
    begin
        s1_word = (fwd_valid_reg && fwd_addr_reg == s1_idx_reg) ? fwd_word_reg : rd_data;
        prev_eff = ({1'b0, s1_idx_reg} < pend_reg) ? s1_word.cur : s1_word.prev;
        new_word.prev = prev_eff;
        new_word.cur = {s1_b_reg, s1_a_reg};
        if (sw_wr_valid_reg)
        begin
            wr_en = 1'b1;
            wr_addr = sw_wr_addr_reg;
            wr_data.prev = rd_data.cur;
            wr_data.cur = rd_data.cur;
        end
        else
        begin
            wr_en = s1_go;
            wr_addr = s1_idx_reg;
            wr_data = new_word;
        end
    end

    gcp_sample_ram u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb
    begin
        tin.step = s1_go;
        tin.final_sample = s1_final_reg;
        tin.hap_a = s1_a_reg;
        tin.hap_b = s1_b_reg;
        tin.compare = have_prev_reg;
        tin.prev = prev_eff;
        tin.ties = s1_ties_reg;
    end

    gcp_tally u_tally (
        .clk   (clk),
        .rst_n (rst_n),
        .tin   (tin),
        .tout  (tout)
    );

    assign orient_het = have_prev_reg ? (orient_reg ^ tout.trans) : 1'b0;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (s1_go && s1_needs_sweep)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (!sw_read)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            index_reg <= '0;
            s1_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            pend_reg <= '0;
            have_prev_reg <= 1'b0;
            orient_reg <= 1'b0;
            sw_rd_reg <= '0;
            sw_end_reg <= '0;
            sw_wr_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sw_wr_valid_reg <= sw_read;

            if (accept)
            begin
                index_reg <= final0 ? '0 : index_reg + IDX_W'(1);
                fwd_valid_reg <= s1_go;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (sw_read)
            begin
                sw_rd_reg <= sw_rd_reg + CNT_W'(1);
            end

            if (s1_go && s1_final_reg)
            begin
                if (s1_needs_sweep)
                begin
                    sw_rd_reg <= s1_len;
                    sw_end_reg <= pend_reg;
                end
                if (tout.geno == GENO_HET)
                begin
                    pend_reg <= s1_len;
                end
                else
                begin
                    pend_reg <= '0;
                end
                if (s1_last_reg)
                begin
                    have_prev_reg <= 1'b0;
                    orient_reg <= 1'b0;
                end
                else if (tout.geno == GENO_HET)
                begin
                    have_prev_reg <= 1'b1;
                    orient_reg <= orient_het;
                end
            end

            if (s1_go && s1_final_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_a_reg <= samples.first_hap_sample;
            s1_b_reg <= samples.second_hap_sample;
            s1_ties_reg <= samples.tie_bits;
            s1_last_reg <= samples.last_site;
            s1_idx_reg <= index_reg;
            s1_final_reg <= final0;
            fwd_addr_reg <= s1_idx_reg;
            fwd_word_reg <= new_word;
        end
        if (sw_read)
        begin
            sw_wr_addr_reg <= sw_rd_reg[IDX_W-1:0];
        end
        if (s1_go && s1_final_reg)
        begin
            out_geno_reg <= tout.geno;
            out_het_reg <= (tout.geno == GENO_HET);
            out_last_reg <= s1_last_reg;
            if (tout.geno == GENO_HET)
            begin
                out_h1_reg <= orient_het;
                out_h2_reg <= ~orient_het;
            end
            else
            begin
                out_h1_reg <= tout.geno[1];
                out_h2_reg <= tout.geno[1];
            end
        end
    end

    assign results.valid = out_valid_reg;
    assign results.hap_first = out_h1_reg;
    assign results.hap_second = out_h2_reg;
    assign results.genotype = out_geno_reg;
    assign results.is_het = out_het_reg;
    assign results.end_of_individual = out_last_reg;

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the genotype consensus phaser core.
`timescale 1ns / 1ps

module testbench;
    import gcp_pkg::*;

    localparam int SETTLE_CYCLES = 1040;
    localparam int STALL_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SMALL_ITEMS   = 300;

    typedef struct packed {
        logic       first_hap_sample;
        logic       second_hap_sample;
        logic [1:0] tie_bits;
        logic       last_site;
    } allele_pair_t;

    typedef struct packed {
        logic       hap_first;
        logic       hap_second;
        logic [1:0] genotype;
        logic       is_het;
        logic       end_of_individual;
    } site_call_t;

    typedef enum int {
        KIND_HOM_REF,
        KIND_HET,
        KIND_HOM_ALT,
        KIND_NOISE
    } site_kind_t;

    class phasing_scoreboard;
        logic [10:0] count_reg;
        int unsigned tally[3];
        int unsigned pos;
        int unsigned agree_n;
        int unsigned disagree_n;
        int unsigned stored_hi;
        bit          phase_bit;
        bit          chain_open;
        logic [1:0]  prev_store[MAX_SAMPLES];
        logic [1:0]  cur_store[MAX_SAMPLES];
        site_call_t  calls_q[$];
        int          errors;
        int          checked;
        int          het_calls;

        function new();
            count_reg  = 11'd1;
            tally      = '{0, 0, 0};
            pos        = 0;
            agree_n    = 0;
            disagree_n = 0;
            stored_hi  = 0;
            phase_bit  = 1'b0;
            chain_open = 1'b0;
            errors     = 0;
            checked    = 0;
            het_calls  = 0;
        endfunction

        function void set_count(input logic [10:0] value);
            count_reg = value;
        endfunction

        function int unsigned effective(input logic [10:0] value);
            if (value == 0)
                return 1;
            if (value > MAX_SAMPLES)
                return MAX_SAMPLES;
            return value;
        endfunction

        function bit at_final();
            return pos + 1 >= effective(count_reg);
        endfunction

        function int pending();
            return calls_q.size();
        endfunction

        function bit step(input allele_pair_t s, output site_call_t call);
            int unsigned n;
            int unsigned i;
            int unsigned best;
            int          g;
            logic [1:0]  geno;
            logic [1:0]  p;
            n = effective(count_reg);
            i = pos;
            call = '0;
            if (i >= MAX_SAMPLES)
                i = MAX_SAMPLES - 1;
            tally[int'(s.first_hap_sample) + int'(s.second_hap_sample)]++;
            cur_store[i] = {s.second_hap_sample, s.first_hap_sample};
            if (chain_open)
            begin
                p = prev_store[i];
                if (s.first_hap_sample == p[0]) agree_n++; else disagree_n++;
                if (s.second_hap_sample == p[1]) agree_n++; else disagree_n++;
            end
            if (i + 1 < n)
            begin
                pos = i + 1;
                return 1'b0;
            end
            geno = GENO_HOM_REF;
            best = 0;
            for (g = 0; g < 3; g++)
            begin
                if (tally[g] == 0)
                    continue;
                if (tally[g] > best || (tally[g] == best && g > 0 && s.tie_bits[g - 1]))
                begin
                    geno = 2'(g);
                    best = tally[g];
                end
            end
            if (geno != GENO_HET)
            begin
                call.hap_first  = geno[1];
                call.hap_second = geno[1];
            end
            else
            begin
                if (!chain_open)
                    phase_bit = 1'b0;
                else if (agree_n < disagree_n)
                    phase_bit = ~phase_bit;
                call.hap_first  = phase_bit;
                call.hap_second = ~phase_bit;
                call.is_het     = 1'b1;
                for (int k = 0; k <= i; k++)
                    prev_store[k] = cur_store[k];
                chain_open = 1'b1;
                if (i + 1 > stored_hi)
                    stored_hi = i + 1;
            end
            call.genotype          = geno;
            call.end_of_individual = s.last_site;
            if (s.last_site)
            begin
                chain_open = 1'b0;
                phase_bit  = 1'b0;
            end
            tally      = '{0, 0, 0};
            pos        = 0;
            agree_n    = 0;
            disagree_n = 0;
            return 1'b1;
        endfunction

        function void note_sample(input allele_pair_t s);
            site_call_t call;
            if (step(s, call))
                calls_q = {calls_q, call};
        endfunction

        function void check_result(input site_call_t got);
            site_call_t want;
            if (calls_q.size() == 0)
            begin
                $error("site call transaction arrived with no site pending");
                errors++;
                return;
            end
            want = calls_q.pop_front();
            checked++;
            if (want.is_het)
                het_calls++;
            if (got.hap_first !== want.hap_first)
            begin
                $error("hap_first: expected %0d, got %0d", want.hap_first, got.hap_first);
                errors++;
            end
            if (got.hap_second !== want.hap_second)
            begin
                $error("hap_second: expected %0d, got %0d", want.hap_second, got.hap_second);
                errors++;
            end
            if (got.genotype !== want.genotype)
            begin
                $error("genotype: expected %0d, got %0d", want.genotype, got.genotype);
                errors++;
            end
            if (got.is_het !== want.is_het)
            begin
                $error("is_het: expected %0d, got %0d", want.is_het, got.is_het);
                errors++;
            end
            if (got.end_of_individual !== want.end_of_individual)
            begin
                $error("end_of_individual: expected %0d, got %0d",
                       want.end_of_individual, got.end_of_individual);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    gcp_cfg_if    cfg_ch();
    gcp_sample_if smp_ch();
    gcp_result_if res_ch();

    genotype_consensus_phaser_core DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (smp_ch),
        .results (res_ch)
    );

    phasing_scoreboard sb   = new();
    phasing_scoreboard plan = new();

    bit          calm;
    int          hold_req;
    int          hold_left;
    int unsigned stall_cycles;
    int unsigned items_sent;
    int unsigned cfg_writes;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (calm)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(99) >= 26);
    end

    always @(posedge clk)
    begin
        if (rst_n && smp_ch.valid && smp_ch.ready)
            sb.note_sample({smp_ch.first_hap_sample, smp_ch.second_hap_sample,
                            smp_ch.tie_bits, smp_ch.last_site});
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result({res_ch.hap_first, res_ch.hap_second, res_ch.genotype,
                             res_ch.is_het, res_ch.end_of_individual});
    end

    always @(posedge clk)
    begin
        if (!rst_n || (smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_sample(input bit a, input bit b, input logic [1:0] ties,
                               input bit last_flag, output bit ended);
        site_call_t unused;
        while (!calm && $urandom_range(99) < 26)
        begin
            smp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        smp_ch.valid             <= 1'b1;
        smp_ch.first_hap_sample  <= a;
        smp_ch.second_hap_sample <= b;
        smp_ch.tie_bits          <= ties;
        smp_ch.last_site         <= last_flag;
        ended = plan.step({a, b, ties, last_flag}, unused);
        items_sent++;
        @(posedge clk);
        while (smp_ch.ready !== 1'b1)
            @(posedge clk);
    endtask

    task automatic send_site(input site_kind_t kind, input int stop_after);
        bit lead;
        bit a;
        bit b;
        bit last_flag;
        bit ended;
        int taken;
        lead  = 1'($urandom_range(1));
        taken = 0;
        do
        begin
            a = 1'($urandom_range(1));
            b = 1'($urandom_range(1));
            if ($urandom_range(99) < 85)
            begin
                case (kind)
                    KIND_HOM_REF:
                    begin
                        a = 1'b0;
                        b = 1'b0;
                    end
                    KIND_HOM_ALT:
                    begin
                        a = 1'b1;
                        b = 1'b1;
                    end
                    KIND_HET:
                    begin
                        a = lead;
                        b = ~lead;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (plan.at_final())
                last_flag = ($urandom_range(99) < 20);
            else
                last_flag = 1'($urandom_range(1));
            send_sample(a, b, 2'($urandom_range(3)), last_flag, ended);
            taken++;
        end
        while (!ended && taken != stop_after);
    endtask

    task automatic write_sample_count(input logic [10:0] value);
        smp_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.sample_count <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        sb.set_count(value);
        plan.set_count(value);
        cfg_writes++;
    endtask

    initial
    begin
        bit          ended;
        int          phase_no;
        int          pick;
        int          sites;
        int unsigned small_start;
        logic [10:0] value;
        site_kind_t  kind;
        logic [1:0]  tie_order[3];

        rst_n                    = 1'b0;
        smp_ch.valid             = 1'b0;
        smp_ch.first_hap_sample  = 1'b0;
        smp_ch.second_hap_sample = 1'b0;
        smp_ch.tie_bits          = 2'b00;
        smp_ch.last_site         = 1'b0;
        res_ch.ready             = 1'b0;
        cfg_ch.valid             = 1'b0;
        cfg_ch.sample_count      = '0;
        calm                     = 1'b0;
        hold_req                 = 0;
        hold_left                = 0;
        items_sent               = 0;
        cfg_writes               = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One sample per site at the reset count: both homozygous calls, then a trans pair.
        send_sample(1'b0, 1'b0, 2'b00, 1'b0, ended);
        send_sample(1'b1, 1'b1, 2'b11, 1'b0, ended);
        send_sample(1'b0, 1'b1, 2'b00, 1'b0, ended);
        send_sample(1'b1, 1'b0, 2'b00, 1'b1, ended);

        write_sample_count(11'd0);
        send_sample(1'b0, 1'b1, 2'b11, 1'b0, ended);
        send_sample(1'b0, 1'b1, 2'b00, 1'b0, ended);
        send_sample(1'b0, 1'b0, 2'b10, 1'b1, ended);

        // Three-way ties settled each way by the tie bits.
        write_sample_count(11'd3);
        tie_order = '{2'b11, 2'b01, 2'b00};
        for (int t = 0; t < 3; t++)
        begin
            send_sample(1'b0, 1'b0, tie_order[t], 1'b0, ended);
            send_sample(1'b0, 1'b1, tie_order[t], 1'b0, ended);
            send_sample(1'b1, 1'b1, tie_order[t], t == 2, ended);
        end

        write_sample_count(11'd4);
        send_sample(1'b1, 1'b0, 2'b00, 1'b0, ended);
        send_sample(1'b0, 1'b1, 2'b00, 1'b0, ended);
        write_sample_count(11'd2);
        send_sample(1'b1, 1'b0, 2'b01, 1'b1, ended);

        // One full-length site, started at a count of 1024 and finished at 2047.
        write_sample_count(11'd1024);
        send_site(KIND_HET, 40);
        write_sample_count(11'd2047);
        send_site(KIND_HET, -1);

        small_start = items_sent;
        phase_no    = 0;
        while (items_sent - small_start < SMALL_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                value = 11'd0;
            else if (pick < 35)
                value = 11'd1;
            else if (pick < 75)
                value = 11'($urandom_range(2, 4));
            else if (pick < 95)
                value = 11'($urandom_range(5, 12));
            else
                value = 11'($urandom_range(13, 64));
            if (phase_no == 0)
                value = 11'd1;
            if (plan.chain_open && plan.effective(value) > plan.stored_hi)
                value = 11'(plan.stored_hi);
            write_sample_count(value);
            calm  = (phase_no < 3);
            sites = (phase_no == 0) ? 40 : $urandom_range(4, 16);
            if (phase_no == 0)
                hold_req = HOLD_CYCLES;
            for (int s = 0; s < sites; s++)
            begin
                if (phase_no == 1 && s == sites / 2)
                begin
                    smp_ch.valid <= 1'b0;
                    @(posedge clk);
                    while (sb.pending() != 0)
                        @(posedge clk);
                end
                pick = $urandom_range(99);
                if (pick < 45)
                    kind = KIND_HET;
                else if (pick < 65)
                    kind = KIND_HOM_REF;
                else if (pick < 85)
                    kind = KIND_HOM_ALT;
                else
                    kind = KIND_NOISE;
                send_site(kind, (s == sites - 1 && $urandom_range(99) < 30)
                                ? $urandom_range(1, 6) : -1);
            end
            calm = 1'b0;
            phase_no++;
        end

        smp_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Run covered %0d samples, %0d site calls (%0d heterozygous), %0d count writes.",
                 items_sent, sb.checked, sb.het_calls, cfg_writes);
        $display("Counts 0, 1, 1024 and 2047, mid-site count changes, a long output stall, a drain.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// File: genotype_consensus_phaser_core.f
sv/gcp_pkg.sv
sv/gcp_if.sv
sv/gcp_sample_ram.sv
sv/gcp_tally.sv
sv/genotype_consensus_phaser_core.sv
bench/testbench.sv
